### rtl/core/hmbf_pkg.sv
// hmbf_pkg: shared widths and register codes for the hybrid median blend filter
// no dependencies; used by the line store, the divider and the top level
package hmbf_pkg;

	localparam int PIX_W = 16;
	localparam int DEN_W = 57;              // h*256 + k*(p-x)^2
	localparam int DVD_W = 58;              // 2*|n|*65536 + den, and 2*den
	localparam int Q_W   = 18;              // quotient bits kept before saturation
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLICES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HGAIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_KGAIN  = 3'd5;

	typedef logic [PIX_W-1:0] pix_t;

endpackage

### rtl/core/hybrid_median_blend_filter_top.sv
// hybrid_median_blend_filter_top: streaming hybrid median blend filter
// depends on hmbf_pkg, hmbf_line_store and hmbf_divider
// requests are handled one at a time; a border pixel is accepted without leaving idle,
//   an interior one runs the one-read-per-cycle tap fetch, the rank pass, four
//   arithmetic steps and the divide step before its result is loaded; the divide step
//   is skipped when the denominator is zero
// reset clears counters, configuration registers and sequencer; the line store and data registers are not cleared
module hybrid_median_blend_filter_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hmbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hmbf_pkg::CFG_DAT_W-1:0]  cfg_data,
	// pixel input channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [15:0]                     pixel,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [9:0]                      col,
	output logic [15:0]                     row,
	output logic [15:0]                     slice,
	output logic [15:0]                     value,
	output logic                            last
);
	import hmbf_pkg::*;

	// geometry of the ring and the tap list
	localparam int RING = 2 * MAX_RADIUS + 1;
	localparam int RW   = $clog2(RING);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int NT   = 1 + 8 * MAX_RADIUS;  // center, then 8 taps per arm distance
	localparam int IW   = $clog2(NT);
	localparam int TW   = $clog2(NT + 1);
	localparam int RDW  = $clog2(MAX_RADIUS + 1);
	localparam int CNW  = $clog2(NT + 3);

	// sequencer codes
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FETCH = 4'd1;
	localparam logic [3:0] S_RANK  = 4'd2;
	localparam logic [3:0] S_SQ    = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_DEN   = 4'd5;
	localparam logic [3:0] S_START = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0] state_q;

	// configuration registers
	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [15:0] slices_q;
	logic [1:0]  radius_q;
	logic [23:0] hgain_q;
	logic [23:0] kgain_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd512;
			height_q <= 16'd512;
			slices_q <= 16'd1;
			radius_q <= 2'd1;
			hgain_q  <= 24'd256;
			kgain_q  <= 24'd13107;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[10:0];
				CFG_HEIGHT: height_q <= cfg_data[15:0];
				CFG_SLICES: slices_q <= cfg_data[15:0];
				CFG_RADIUS: radius_q <= cfg_data[1:0];
				CFG_HGAIN:  hgain_q  <= cfg_data;
				CFG_KGAIN:  kgain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective geometry: zero acts as one, width and radius capped
	logic [CW:0]    w_eff;
	logic [15:0]    h_eff;
	logic [15:0]    s_eff;
	logic [RDW-1:0] rad_eff;

	always_comb begin
		if (width_q == '0) begin
			w_eff = (CW+1)'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = (CW+1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW+1)'(width_q);
		end
		h_eff = (height_q == '0) ? 16'd1 : height_q;
		s_eff = (slices_q == '0) ? 16'd1 : slices_q;
		if (radius_q == '0) begin
			rad_eff = RDW'(1);
		end else if (32'(radius_q) > MAX_RADIUS) begin
			rad_eff = RDW'(MAX_RADIUS);
		end else begin
			rad_eff = RDW'(radius_q);
		end
	end

	// raster position counters and ring row of the current row
	logic [CW-1:0] pos_col_q;
	logic [15:0]   pos_row_q;
	logic [15:0]   pos_slc_q;
	logic [RW-1:0] ring_row_q;

	logic in_acc;
	logic produce;
	logic last_d;
	logic col_wrap;
	logic row_wrap;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	// interior test for the window centred rad back from the newest pixel
	assign produce = (32'(pos_col_q) < 32'(w_eff)) && (pos_row_q < h_eff)
		&& (pos_slc_q < s_eff)
		&& (32'(pos_col_q) >= 32'({rad_eff, 1'b0}))
		&& (32'(pos_row_q) >= 32'({rad_eff, 1'b0}));
	assign last_d = (32'(pos_col_q) == 32'(w_eff) - 32'd1)
		&& (pos_row_q == h_eff - 16'd1) && (pos_slc_q == s_eff - 16'd1);
	assign col_wrap = 32'(pos_col_q) + 32'd1 >= 32'(w_eff);
	assign row_wrap = 32'(pos_row_q) + 32'd1 >= 32'(h_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_col_q  <= '0;
			pos_row_q  <= '0;
			pos_slc_q  <= '0;
			ring_row_q <= '0;
		end else if (in_acc) begin
			if (col_wrap) begin
				pos_col_q <= '0;
				if (row_wrap) begin
					pos_row_q  <= '0;
					ring_row_q <= '0;
					pos_slc_q  <= (32'(pos_slc_q) + 32'd1 >= 32'(s_eff)) ? 16'd0
						: pos_slc_q + 16'd1;
				end else begin
					pos_row_q  <= pos_row_q + 16'd1;
					ring_row_q <= (ring_row_q == RW'(RING - 1)) ? '0
						: ring_row_q + RW'(1);
				end
			end else begin
				pos_col_q <= pos_col_q + CW'(1);
			end
		end
	end

	// request context latched at accept
	logic [CW-1:0]  cur_col_q;
	logic [15:0]    cur_row_q;
	logic [15:0]    cur_slc_q;
	logic [RW-1:0]  cur_ring_q;
	logic           cur_last_q;
	logic [RDW-1:0] rad_q;
	logic [TW-1:0]  ntap_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_col_q  <= pos_col_q;
			cur_row_q  <= pos_row_q;
			cur_slc_q  <= pos_slc_q;
			cur_ring_q <= ring_row_q;
			cur_last_q <= last_d;
			rad_q      <= rad_eff;
			ntap_q     <= TW'(1) + TW'({rad_eff, 3'b000});
		end
	end

	// tap fetch: one line store read per cycle, tap 0 is the center, then per arm
	// distance d: right, left, down, up, down-right, up-left, down-left, up-right
	logic [TW-1:0]   fetch_q;
	logic [TW-1:0]   fetch_s1;
	logic            rd_v_s1;
	logic [TW-1:0]   tm1;
	logic [RDW-1:0]  tap_d;
	logic [2:0]      tap_k;
	logic [RDW:0]    back_c;
	logic [RDW:0]    back_r;
	logic [CW-1:0]   tap_col;
	logic [RW-1:0]   tap_row;
	logic            rd_en;
	pix_t            rd_data;

	always_comb begin
		tm1    = fetch_q - TW'(1);
		tap_d  = RDW'(tm1 >> 3) + RDW'(1);
		tap_k  = tm1[2:0];
		back_c = (RDW+1)'(rad_q);
		back_r = (RDW+1)'(rad_q);
		if (fetch_q != '0) begin
			case (tap_k)
				3'd0: back_c = (RDW+1)'(rad_q) - (RDW+1)'(tap_d);
				3'd1: back_c = (RDW+1)'(rad_q) + (RDW+1)'(tap_d);
				3'd2: back_r = (RDW+1)'(rad_q) - (RDW+1)'(tap_d);
				3'd3: back_r = (RDW+1)'(rad_q) + (RDW+1)'(tap_d);
				3'd4: begin
					back_c = (RDW+1)'(rad_q) - (RDW+1)'(tap_d);
					back_r = (RDW+1)'(rad_q) - (RDW+1)'(tap_d);
				end
				3'd5: begin
					back_c = (RDW+1)'(rad_q) + (RDW+1)'(tap_d);
					back_r = (RDW+1)'(rad_q) + (RDW+1)'(tap_d);
				end
				3'd6: begin
					back_c = (RDW+1)'(rad_q) + (RDW+1)'(tap_d);
					back_r = (RDW+1)'(rad_q) - (RDW+1)'(tap_d);
				end
				default: begin
					back_c = (RDW+1)'(rad_q) - (RDW+1)'(tap_d);
					back_r = (RDW+1)'(rad_q) + (RDW+1)'(tap_d);
				end
			endcase
		end
		tap_col = cur_col_q - CW'(back_c);
		// ring row, modulo the ring depth
		if ((RW+1)'(cur_ring_q) >= (RW+1)'(back_r)) begin
			tap_row = RW'((RW+1)'(cur_ring_q) - (RW+1)'(back_r));
		end else begin
			tap_row = RW'((RW+1)'(cur_ring_q) + (RW+1)'(RING) - (RW+1)'(back_r));
		end
	end

	assign rd_en = (state_q == S_FETCH) && (fetch_q < ntap_q);

	hmbf_line_store #(
		.ROWS (RING),
		.COLS (MAX_WIDTH)
	) u_store (
		.clk   (clk),
		.we    (in_acc),
		.wrow  (ring_row_q),
		.wcol  (pos_col_q),
		.wdata (pixel),
		.re    (rd_en),
		.rrow  (tap_row),
		.rcol  (tap_col),
		.rdata (rd_data)
	);

	pix_t tap_q [NT];

	always_ff @(posedge clk) begin
		fetch_s1 <= fetch_q;
		if (rd_v_s1) begin
			tap_q[fetch_s1[IW-1:0]] <= rd_data;
		end
	end

	// rank pass: each tap in turn is the candidate, counted against all taps
	logic [TW-1:0]  cand_q;
	logic [TW-1:0]  cand_m1;
	pix_t           cand;
	logic           cand_plus;
	logic [CNW-1:0] lt_p, le_p, lt_x, le_x, lt_w, le_w;
	logic [CNW-1:0] thr_p, thr_w;

	assign cand      = tap_q[cand_q[IW-1:0]];
	assign cand_m1   = cand_q - TW'(1);
	assign cand_plus = (cand_q == '0) || (cand_m1[2:0] < 3'd4);

	assign thr_p = CNW'({rad_q, 1'b0});
	assign thr_w = CNW'({rad_q, 1'b0}) + CNW'(1);

	always_comb begin
		lt_p = '0;
		le_p = '0;
		lt_x = '0;
		le_x = '0;
		for (int j = 0; j < NT; j++) begin
			if (TW'(j) < ntap_q) begin
				if (j == 0 || ((j - 1) % 8) < 4) begin
					lt_p = lt_p + CNW'(tap_q[j] < cand);
					le_p = le_p + CNW'(tap_q[j] <= cand);
				end
				if (j == 0 || ((j - 1) % 8) >= 4) begin
					lt_x = lt_x + CNW'(tap_q[j] < cand);
					le_x = le_x + CNW'(tap_q[j] <= cand);
				end
			end
		end
		// weighted set counts the center two more times
		lt_w = lt_p + ((tap_q[0] < cand) ? CNW'(2) : CNW'(0));
		le_w = le_p + ((tap_q[0] <= cand) ? CNW'(2) : CNW'(0));
	end

	// medians and the blend arithmetic
	pix_t               med_p_q, med_w_q, med_x_q;
	logic [31:0]        sq_q;
	logic [55:0]        prod_q;
	logic [DEN_W-1:0]   den_q;
	logic [Q_W-1:0]     mag_q;
	logic               neg_q;
	logic               zero_den_q;
	logic signed [16:0] diff;
	logic signed [33:0] diff_sq;
	logic signed [18:0] num;

	assign diff    = $signed({1'b0, med_p_q}) - $signed({1'b0, med_x_q});
	assign diff_sq = diff * diff;
	assign num     = $signed({3'b000, med_p_q}) + $signed({3'b000, med_x_q})
		- $signed({2'b00, med_w_q, 1'b0});

	logic             div_start;
	logic             div_done;
	logic [Q_W-1:0]   div_quot;
	logic             div_ovf;

	assign div_start = (state_q == S_START) && (den_q != '0);

	hmbf_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DVD_W'({mag_q, 17'd0}) + DVD_W'(den_q)),
		.divisor  ({den_q, 1'b0}),
		.done     (div_done),
		.quot     (div_quot),
		.ovf      (div_ovf)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_RANK) begin
			if (cand_plus && lt_p <= thr_p && le_p > thr_p) begin
				med_p_q <= cand;
			end
			if (cand_plus && lt_w <= thr_w && le_w > thr_w) begin
				med_w_q <= cand;
			end
			if (!cand_plus && lt_x <= thr_p && le_x > thr_p) begin
				med_x_q <= cand;
			end
			// center belongs to the cross set as well
			if (cand_q == '0 && lt_x <= thr_p && le_x > thr_p) begin
				med_x_q <= cand;
			end
		end
		if (state_q == S_SQ) begin
			sq_q  <= diff_sq[31:0];
			neg_q <= num < 0;
			mag_q <= (num < 0) ? Q_W'(-num) : Q_W'(num);
		end
		if (state_q == S_MUL) begin
			prod_q <= 56'(kgain_q) * 56'(sq_q);
		end
		if (state_q == S_DEN) begin
			den_q <= DEN_W'({hgain_q, 8'd0}) + DEN_W'(prod_q);
		end
		if (state_q == S_START) begin
			zero_den_q <= (den_q == '0);
		end
	end

	// final correction, rounded and saturated
	logic signed [19:0] sum;
	pix_t               res;

	always_comb begin
		sum = neg_q ? $signed({4'd0, med_w_q}) - $signed({2'd0, div_quot})
			: $signed({4'd0, med_w_q}) + $signed({2'd0, div_quot});
		if (zero_den_q) begin
			res = med_w_q;
		end else if (div_ovf) begin
			res = neg_q ? 16'd0 : 16'hFFFF;
		end else if (sum < 0) begin
			res = 16'd0;
		end else if (sum > 20'sd65535) begin
			res = 16'hFFFF;
		end else begin
			res = sum[15:0];
		end
	end

	// output register
	logic       out_valid_q;
	logic       out_load;
	logic [9:0] col_o_q;
	logic [15:0] row_o_q;
	logic [15:0] slc_o_q;
	pix_t        val_o_q;
	logic        last_o_q;

	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (out_load) begin
			col_o_q  <= 10'(32'(cur_col_q) - 32'(rad_q));
			row_o_q  <= cur_row_q - 16'(rad_q);
			slc_o_q  <= cur_slc_q;
			val_o_q  <= res;
			last_o_q <= cur_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign col       = col_o_q;
	assign row       = row_o_q;
	assign slice     = slc_o_q;
	assign value     = val_o_q;
	assign last      = last_o_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fetch_q     <= '0;
			rd_v_s1     <= 1'b0;
			cand_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					fetch_q <= '0;
					cand_q  <= '0;
					if (in_acc && produce) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					if (rd_en) begin
						fetch_q <= fetch_q + TW'(1);
					end else if (!rd_v_s1) begin
						state_q <= S_RANK;
					end
				end
				S_RANK: begin
					cand_q <= cand_q + TW'(1);
					if (cand_q + TW'(1) == ntap_q) begin
						state_q <= S_SQ;
					end
				end
				S_SQ:    state_q <= S_MUL;
				S_MUL:   state_q <= S_DEN;
				S_DEN:   state_q <= S_START;
				S_START: state_q <= (den_q == '0) ? S_OUT : S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks on the sequencer
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide step");

	a_fetch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH |-> fetch_q <= ntap_q)
		else $error("tap fetch ran past the tap count");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == S_IDLE)
		else $error("result load did not raise valid");

endmodule

### rtl/core/hmbf_line_store.sv
// hmbf_line_store: row ring of the most recent rows, one write and one read port
// depends on hmbf_pkg for the pixel type; read data is registered
module hmbf_line_store #(
	parameter int ROWS = 7,
	parameter int COLS = 1024
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [$clog2(ROWS)-1:0] wrow,
	input  logic [$clog2(COLS)-1:0] wcol,
	input  hmbf_pkg::pix_t          wdata,
	input  logic                    re,
	input  logic [$clog2(ROWS)-1:0] rrow,
	input  logic [$clog2(COLS)-1:0] rcol,
	output hmbf_pkg::pix_t          rdata
);
	import hmbf_pkg::*;

	pix_t store_q [ROWS][COLS];
	pix_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[wrow][wcol] <= wdata;
		end
		if (re) begin
			rdata_q <= store_q[rrow][rcol];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/hmbf_divider.sv
// hmbf_divider: restoring divider, one quotient bit per cycle
// depends on hmbf_pkg for widths; flags quotients that do not fit in Q_W bits
module hmbf_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [hmbf_pkg::DVD_W-1:0]    dividend,
	input  logic [hmbf_pkg::DVD_W-1:0]    divisor,
	output logic                          done,
	output logic [hmbf_pkg::Q_W-1:0]      quot,
	output logic                          ovf
);
	import hmbf_pkg::*;

	localparam int SH_W = DVD_W + Q_W;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] rem_q;
	logic [SH_W-1:0]  dsh_q;
	logic [Q_W-1:0]   quot_q;
	logic             ovf_q;
	logic             fits;

	// trial subtract of the shifted divisor
	assign fits = SH_W'(rem_q) >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsh_q  <= SH_W'(divisor) << (Q_W - 1);
			ovf_q  <= SH_W'(dividend) >= (SH_W'(divisor) << Q_W);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DVD_W'(SH_W'(rem_q) - dsh_q);
			end
			quot_q <= {quot_q[Q_W-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign ovf  = ovf_q;

endmodule
